[rtl/cpf_pkg.sv]
// Shared constants, control word type, microcode table and CRC step for the packet framer.
`timescale 1ns / 1ps
package cpf_pkg;

  // Stream widths
  localparam int unsigned CMD_W      = 8;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned PAYLOAD_W  = 64;
  localparam int unsigned S_TDATA_W  = 80;  // 76 field bits padded to whole bytes
  localparam int unsigned M_TDATA_W  = 8;
  localparam int unsigned MAX_PAYLOAD_BYTES = 8;

  // Frame constants
  localparam logic [7:0]  SOF0_BYTE = 8'h55;
  localparam logic [7:0]  SOF1_BYTE = 8'h66;
  localparam logic [7:0]  CTRL_BYTE = 8'h01;
  localparam logic [7:0]  ZERO_BYTE = 8'h00;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_SEED  = 16'h0000;

  // Byte source codes
  localparam int unsigned SRC_W = 3;
  localparam logic [SRC_W-1:0] SRC_CONST = 3'd0;
  localparam logic [SRC_W-1:0] SRC_LEN   = 3'd1;
  localparam logic [SRC_W-1:0] SRC_SEQL  = 3'd2;
  localparam logic [SRC_W-1:0] SRC_SEQH  = 3'd3;
  localparam logic [SRC_W-1:0] SRC_CMD   = 3'd4;
  localparam logic [SRC_W-1:0] SRC_PAY   = 3'd5;
  localparam logic [SRC_W-1:0] SRC_CRCL  = 3'd6;
  localparam logic [SRC_W-1:0] SRC_CRCH  = 3'd7;

  // Sequencing codes
  localparam int unsigned COND_W = 2;
  localparam logic [COND_W-1:0] COND_NEXT  = 2'd0;  // fall through
  localparam logic [COND_W-1:0] COND_SKIP  = 2'd1;  // jump to target when no payload
  localparam logic [COND_W-1:0] COND_LOOP  = 2'd2;  // repeat until last payload byte
  localparam logic [COND_W-1:0] COND_DONE  = 2'd3;  // frame complete

  // Step addresses
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_SOF0 = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SOF1 = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CTRL = 4'd2;
  localparam logic [STEP_W-1:0] STEP_LENL = 4'd3;
  localparam logic [STEP_W-1:0] STEP_LENH = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SEQL = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SEQH = 4'd6;
  localparam logic [STEP_W-1:0] STEP_CMD  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_PAY  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_CRCL = 4'd9;
  localparam logic [STEP_W-1:0] STEP_CRCH = 4'd10;

  // One microcode word
  typedef struct packed {
    logic [SRC_W-1:0]  src;
    logic [7:0]        lit;
    logic              crc_en;
    logic              last;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } cpf_ctrl_t;

  // Microcode program, one word per emitted frame byte
  function automatic cpf_ctrl_t cpf_rom(input logic [STEP_W-1:0] step);
    cpf_ctrl_t w;
    w = '{src: SRC_CONST, lit: ZERO_BYTE, crc_en: 1'b0, last: 1'b0,
          cond: COND_NEXT, target: STEP_SOF0};
    case (step)
      STEP_SOF0: begin w.lit = SOF0_BYTE; w.crc_en = 1'b1; end
      STEP_SOF1: begin w.lit = SOF1_BYTE; w.crc_en = 1'b1; end
      STEP_CTRL: begin w.lit = CTRL_BYTE; w.crc_en = 1'b1; end
      STEP_LENL: begin w.src = SRC_LEN;   w.crc_en = 1'b1; end
      STEP_LENH: begin w.lit = ZERO_BYTE; w.crc_en = 1'b1; end
      STEP_SEQL: begin w.src = SRC_SEQL;  w.crc_en = 1'b1; end
      STEP_SEQH: begin w.src = SRC_SEQH;  w.crc_en = 1'b1; end
      STEP_CMD: begin
        w.src = SRC_CMD; w.crc_en = 1'b1; w.cond = COND_SKIP; w.target = STEP_CRCL;
      end
      STEP_PAY: begin
        w.src = SRC_PAY; w.crc_en = 1'b1; w.cond = COND_LOOP;
      end
      STEP_CRCL: begin w.src = SRC_CRCL; end
      STEP_CRCH: begin w.src = SRC_CRCH; w.last = 1'b1; w.cond = COND_DONE; end
      default: begin w.cond = COND_DONE; end
    endcase
    return w;
  endfunction

  // CRC-16 (poly 0x1021, MSB first) over one byte
  function automatic logic [15:0] cpf_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[rtl/command_packet_framer_unit.sv]
// Command packet framer: microcoded byte sequencer with running CRC-16 and output register.
`timescale 1ns / 1ps
// Frames one command per request into a byte stream: 55 66 01, length (16b LE), sequence
// number (16b LE), command id, payload bytes, then CRC-16/XMODEM (16b LE) over all prior
// bytes; m_axis_tlast marks the CRC high byte. A frame of L payload bytes is 10+L bytes
// and leaves one byte per cycle unless the downstream side stalls, one microcode step per
// byte. A new command is taken once the last byte has been loaded into the output register.
// While link_enabled is 0 commands are accepted and dropped, and the sequence number holds.
// Lengths above MaxPayloadBytes saturate to it.
module command_packet_framer_unit
  import cpf_pkg::*;
#(
  parameter int unsigned MaxPayloadBytes = cpf_pkg::MAX_PAYLOAD_BYTES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: link_enabled
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i,
  // Command requests
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // command_id [7:0], payload_length [11:8], payload [75:12], zero pad [79:76]
  input  logic [cpf_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // Frame bytes
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // frame_byte [7:0]
  output logic [cpf_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // last_byte
  output logic                          m_axis_tlast
);

  localparam int unsigned LenW = $clog2(MaxPayloadBytes + 1);
  localparam int unsigned PayW = 8 * MaxPayloadBytes;
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MaxPayloadBytes);

  logic              link_q;
  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [LenW-1:0]   rem_q, rem_d;
  logic [15:0]       seq_q, seq_d;
  logic [15:0]       crc_q, crc_d;
  logic [CMD_W-1:0]  cmd_q;
  logic [PayW-1:0]   payload_q;
  logic              m_valid_q;
  logic [7:0]        m_data_q;
  logic              m_last_q;

  cpf_ctrl_t         ctrl;
  logic [7:0]        byte_sel;
  logic              advance;
  logic              take;
  logic [LEN_W-1:0]  in_len;
  logic [LenW-1:0]   len_sat;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ~busy_q;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  assign take    = s_axis_tvalid & ~busy_q & link_q;
  assign advance = busy_q & (~m_valid_q | m_axis_tready);
  assign in_len  = s_axis_tdata[CMD_W +: LEN_W];
  assign len_sat = LenW'((in_len > MaxLen) ? MaxLen : in_len);

  // Current microcode word
  assign ctrl = cpf_rom(step_q);

  // Byte source select
  always_comb begin
    case (ctrl.src)
      SRC_CONST: byte_sel = ctrl.lit;
      SRC_LEN:   byte_sel = 8'(rem_q);
      SRC_SEQL:  byte_sel = seq_q[7:0];
      SRC_SEQH:  byte_sel = seq_q[15:8];
      SRC_CMD:   byte_sel = cmd_q;
      SRC_PAY:   byte_sel = payload_q[7:0];
      SRC_CRCL:  byte_sel = crc_q[7:0];
      SRC_CRCH:  byte_sel = crc_q[15:8];
      default:   byte_sel = ctrl.lit;
    endcase
  end

  // Sequencer next state
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    seq_d  = seq_q;
    crc_d  = crc_q;
    if (take) begin
      busy_d = 1'b1;
      step_d = STEP_SOF0;
      rem_d  = len_sat;
      crc_d  = CRC_SEED;
    end else if (advance) begin
      if (ctrl.crc_en) begin
        crc_d = cpf_crc_byte(crc_q, byte_sel);
      end
      case (ctrl.cond)
        COND_NEXT: step_d = step_q + STEP_W'(1);
        COND_SKIP: step_d = (rem_q == '0) ? ctrl.target : step_q + STEP_W'(1);
        COND_LOOP: begin
          rem_d = rem_q - LenW'(1);
          if (rem_q == LenW'(1)) begin
            step_d = step_q + STEP_W'(1);
          end
        end
        COND_DONE: begin
          busy_d = 1'b0;
          seq_d  = seq_q + 16'd1;
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q    <= 1'b0;
      busy_q    <= 1'b0;
      step_q    <= STEP_SOF0;
      rem_q     <= '0;
      seq_q     <= 16'd0;
      crc_q     <= CRC_SEED;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        link_q <= cfg_data_i;
      end
      busy_q <= busy_d;
      step_q <= step_d;
      rem_q  <= rem_d;
      seq_q  <= seq_d;
      crc_q  <= crc_d;
      if (advance) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload and output data registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q     <= s_axis_tdata[CMD_W-1:0];
      payload_q <= s_axis_tdata[CMD_W+LEN_W +: PayW];
    end else if (advance && ctrl.src == SRC_PAY) begin
      payload_q <= payload_q >> 8;
    end
    if (advance) begin
      m_data_q <= byte_sel;
      m_last_q <= ctrl.last;
    end
  end

endmodule

[rtl/cpf_checker.sv]
// Port-level checks for the packet framer, bound to the top level.
`timescale 1ns / 1ps
module cpf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [cpf_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);
  import cpf_pkg::*;

  // A stalled frame byte holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("frame byte changed while stalled");

  // No new command while a frame is still being sent
  a_busy_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("command taken in the middle of a frame");

  // Output never gaps inside a frame, so a fresh run starts with the first sync byte
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> m_axis_tdata == SOF0_BYTE)
    else $error("frame does not start with sync byte");

  // A byte that follows the last byte of a frame is a sync byte
  a_next_sof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast ##1 m_axis_tvalid |->
      m_axis_tdata == SOF0_BYTE)
    else $error("frame follows without sync byte");

endmodule

bind command_packet_framer_unit cpf_checker u_cpf_checker (.*);

[tb/sv/tb_top.sv]
// Self-checking testbench for the command packet framer: directed and random command streams.
`timescale 1ns / 1ps
module tb_top;
  import cpf_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned HOLD_CYCLES  = 150;

  // One expected frame byte
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_byte_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic                 cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // command_id [7:0], payload_length [11:8], payload [75:12], zero pad [79:76]
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // frame_byte [7:0]
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  // Shadow state of the framer
  logic [15:0]  seq_number;
  bit           link_on;
  frame_byte_t  pending_bytes_q[$];

  int unsigned  mismatch_count;
  bit           quiet;
  bit           hold_req;

  command_packet_framer_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Bit-serial CRC-16/XMODEM update, MSB first
  function automatic logic [15:0] xmodem_update(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ data[i];
      r  = {r[14:0], 1'b0};
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  // Expected frame for one accepted command; nothing while the link is off
  function automatic void predict_frame(input logic [7:0] cmd, input logic [3:0] len_in,
                                        input logic [63:0] payload);
    logic [7:0]  bytes[$];
    logic [15:0] crc;
    int unsigned nbytes;
    frame_byte_t fb;
    if (!link_on) return;
    nbytes = (len_in > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES : len_in;
    bytes = '{SOF0_BYTE, SOF1_BYTE, CTRL_BYTE, 8'(nbytes), ZERO_BYTE,
              seq_number[7:0], seq_number[15:8], cmd};
    for (int i = 0; i < nbytes; i++) bytes = {bytes, payload[8*i +: 8]};
    crc = CRC_SEED;
    foreach (bytes[i]) crc = xmodem_update(crc, bytes[i]);
    bytes = {bytes, crc[7:0]};
    bytes = {bytes, crc[15:8]};
    foreach (bytes[i]) begin
      fb.frame_byte = bytes[i];
      fb.last_byte  = (i == bytes.size() - 1);
      pending_bytes_q = {pending_bytes_q, fb};
    end
    seq_number = seq_number + 16'd1;
  endfunction

  // Send one command request; returns at the accepting edge
  task automatic send_command(input logic [7:0] cmd, input logic [3:0] len_in,
                              input logic [63:0] payload);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, payload, len_in, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_frame(cmd, len_in, payload);
  endtask

  // Drop the request line and let every expected byte come out
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_link_enable(input bit en);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= en;
    do @(posedge clk_i); while (!cfg_ready_o);
    link_on = en;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [3:0] random_length();
    // Mostly legal lengths, some oversized ones
    return ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
  endfunction

  // Frame byte receiver with random stalls and a long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each frame byte with the oldest expectation
  always @(posedge clk_i) begin
    frame_byte_t exp_b;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_bytes_q.size() == 0) begin
        $error("unexpected frame byte %02h (tlast %0b)", m_axis_tdata, m_axis_tlast);
        mismatch_count++;
      end else begin
        exp_b = pending_bytes_q.pop_front();
        if (m_axis_tdata !== exp_b.frame_byte) begin
          $error("frame_byte: expected %02h, actual %02h", exp_b.frame_byte, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tlast !== exp_b.last_byte) begin
          $error("last_byte: expected %0b, actual %0b", exp_b.last_byte, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Link is off after reset: commands vanish
  task automatic test_reset_link_off();
    send_command(8'h12, 4'd5, 64'h1122_3344_5566_7788);
    send_command(8'hFF, 4'd15, '1);
    send_command(8'h00, 4'd0, '0);
    wait_idle();
  endtask

  // Field extremes, oversized lengths, junk above the length
  task automatic test_directed_frames();
    write_link_enable(1'b1);
    send_command(8'h00, 4'd0, '0);
    send_command(8'hFF, 4'd0, '1);
    send_command(8'hA5, 4'd8, '1);
    send_command(8'h5A, 4'd8, '0);
    send_command(8'h3C, 4'd1, 64'hFFFF_FFFF_FFFF_FF12);
    send_command(8'hC3, 4'd4, 64'h0123_4567_89AB_CDEF);
    send_command(8'h81, 4'd9, {$urandom, $urandom});
    send_command(8'h7E, 4'd12, {$urandom, $urandom});
    send_command(8'h42, 4'd15, {$urandom, $urandom});
    send_command(8'h18, 4'd7, 64'hAAAA_5555_AAAA_5555);
  endtask

  // Disabling drops commands and keeps the sequence number
  task automatic test_link_toggle();
    write_link_enable(1'b0);
    send_command(8'h99, 4'd3, {$urandom, $urandom});
    send_command(8'h66, 4'd8, {$urandom, $urandom});
    write_link_enable(1'b1);
    send_command(8'h01, 4'd2, {$urandom, $urandom});
    send_command(8'h02, 4'd0, {$urandom, $urandom});
  endtask

  // Long receiver hold-off while commands keep coming
  task automatic test_output_backpressure();
    wait_idle();
    hold_req = 1'b1;
    repeat (12) send_command(8'($urandom), 4'd8, {$urandom, $urandom});
  endtask

  task automatic run_random_phase(input bit en, input int unsigned count);
    write_link_enable(en);
    repeat (count) send_command(8'($urandom), random_length(), {$urandom, $urandom});
  endtask

  // Main sequence
  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    seq_number     = '0;
    link_on        = 1'b0;
    mismatch_count = 0;
    quiet          = 1'b0;
    hold_req       = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_link_off();
    test_directed_frames();
    test_link_toggle();
    test_output_backpressure();
    run_random_phase(1'b1, 50);
    run_random_phase(1'b0, 20);
    run_random_phase(1'b1, 50);
    quiet = 1'b1;
    run_random_phase(1'b1, 50);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
